[design/segment_timeline_mapper_defines.svh]
// Assertion macros for the segment timeline mapper top module.
`ifndef SEGMENT_TIMELINE_MAPPER_DEFINES_SVH
`define SEGMENT_TIMELINE_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define STM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment timeline mapper check failed");
`define STM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment timeline mapper check failed");
`else
`define STM_ASSERT_NOW(label, ante, cons)
`define STM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/stm_pkg.sv]
// Types, codes and helpers shared by the segment timeline mapper modules.
package stm_pkg;

    localparam int TIME_W          = 31;
    localparam int GTIME_W         = 32;
    localparam int ACTION_W        = 2;
    localparam int STATUS_W        = 2;
    localparam int INDEX_OUT_W     = 4;
    localparam int MAX_SEGMENTS_DEF = 16;

    localparam logic [TIME_W-1:0]         TIME_MAX  = {TIME_W{1'b1}};
    localparam logic signed [GTIME_W-1:0] GTIME_MAX = {1'b0, {(GTIME_W-1){1'b1}}};

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEEK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BACKWARD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_SEEK_DONE,
        S_REP_CALC,
        S_REP_OUT
    } fsm_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] beg_ms;
        logic [TIME_W-1:0] fin_ms;
    } seg_entry_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [TIME_W-1:0] hit_begin;
        logic [TIME_W-1:0] hit_off;
        logic [TIME_W-1:0] hit_before;
    } walk_res_t;

    function automatic logic [TIME_W-1:0] sat_add31(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

endpackage

[design/stm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module stm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/stm_walk.sv]
// Seek walker: streams the segment table and finds the segment holding a global time.
module stm_walk
    import stm_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0] count,
    input  logic [TIME_W-1:0]                 target,
    output logic                              rd_en,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   rd_addr,
    input  seg_entry_t                        rd_data,
    output walk_res_t                         res,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   hit_idx
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [TIME_W:0] SUM_CLAMP = {1'b1, {TIME_W{1'b0}}};

    logic              running_reg, running_next;
    logic              done_reg, done_next;
    logic              issuing_reg, issuing_next;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              s1_v_reg, s1_v_next;
    logic [IDX_W-1:0]  s1_idx_reg, s1_idx_next;
    logic              s2_v_reg, s2_v_next;
    logic [IDX_W-1:0]  s2_idx_reg, s2_idx_next;
    logic [TIME_W-1:0] len_reg, len_next;
    logic [TIME_W-1:0] beg_reg, beg_next;
    logic [TIME_W:0]   end_sum_reg, end_sum_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [TIME_W-1:0] hit_begin_reg, hit_begin_next;
    logic [TIME_W-1:0] hit_off_reg, hit_off_next;
    logic [TIME_W-1:0] hit_before_reg, hit_before_next;
    logic [TIME_W+1:0] sum_wide;
    logic [TIME_W:0]   sum_sat;

    always_comb
    begin
        running_next    = running_reg;
        done_next       = done_reg;
        issuing_next    = issuing_reg;
        issue_idx_next  = issue_idx_reg;
        s1_v_next       = issuing_reg;
        s1_idx_next     = issue_idx_reg[IDX_W-1:0];
        s2_v_next       = s1_v_reg;
        s2_idx_next     = s1_idx_reg;
        len_next        = rd_data.fin_ms - rd_data.beg_ms;
        beg_next        = rd_data.beg_ms;
        end_sum_next    = end_sum_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_begin_next  = hit_begin_reg;
        hit_off_next    = hit_off_reg;
        hit_before_next = hit_before_reg;

        sum_wide = {1'b0, end_sum_reg} + {2'b00, len_reg};
        sum_sat  = (sum_wide >= {1'b0, SUM_CLAMP}) ? SUM_CLAMP : sum_wide[TIME_W:0];

        if (issuing_reg)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
            if (issue_idx_next == count)
            begin
                issuing_next = 1'b0;
            end
        end

        if (s2_v_reg)
        begin
            end_sum_next = sum_sat;
            if (!found_reg && ({1'b0, target} < sum_sat))
            begin
                found_next      = 1'b1;
                hit_idx_next    = s2_idx_reg;
                hit_begin_next  = beg_reg;
                hit_off_next    = target - end_sum_reg[TIME_W-1:0];
                hit_before_next = end_sum_reg[TIME_W-1:0];
            end
        end

        if (running_reg && !issuing_reg && !s1_v_reg && !s2_v_reg)
        begin
            running_next = 1'b0;
            done_next    = 1'b1;
        end

        if (start)
        begin
            running_next   = 1'b1;
            done_next      = 1'b0;
            issuing_next   = 1'b1;
            issue_idx_next = '0;
            s1_v_next      = 1'b0;
            s2_v_next      = 1'b0;
            end_sum_next   = '0;
            found_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            issuing_reg <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            issuing_reg <= issuing_next;
            s1_v_reg    <= s1_v_next;
            s2_v_reg    <= s2_v_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg  <= issue_idx_next;
        s1_idx_reg     <= s1_idx_next;
        s2_idx_reg     <= s2_idx_next;
        len_reg        <= len_next;
        beg_reg        <= beg_next;
        end_sum_reg    <= end_sum_next;
        hit_idx_reg    <= hit_idx_next;
        hit_begin_reg  <= hit_begin_next;
        hit_off_reg    <= hit_off_next;
        hit_before_reg <= hit_before_next;
    end

    assign rd_en          = issuing_reg;
    assign rd_addr        = issue_idx_reg[IDX_W-1:0];
    assign res.done       = done_reg;
    assign res.found      = found_reg;
    assign res.hit_begin  = hit_begin_reg;
    assign res.hit_off    = hit_off_reg;
    assign res.hit_before = hit_before_reg;
    assign hit_idx        = hit_idx_reg;

endmodule

[design/segment_timeline_mapper.sv]
// Segment timeline mapper: segment table in RAM, seek walk and position reports.
// Append and rejected items go from S_EXEC straight to the result register; reports go
// through S_EXEC, S_REP_CALC and S_REP_OUT. Seek: the walker reads the N stored segments,
// one table entry per cycle on the RAM port. Only one item is in work at a time.
// A new item is taken while the previous result waits in the output register.
// Reset clears all control state at once; the segment RAM is not cleared and needs no sweep.
`include "segment_timeline_mapper_defines.svh"
module segment_timeline_mapper
    import stm_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [ACTION_W-1:0]        action,
    input  logic [TIME_W-1:0]          seg_begin,
    input  logic [TIME_W-1:0]          seg_finish,
    input  logic [TIME_W-1:0]          time_value,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [GTIME_W-1:0]  global_time,
    output logic                       time_valid,
    output logic [INDEX_OUT_W-1:0]     segment_index,
    output logic                       load_request,
    output logic [TIME_W-1:0]          load_time,
    output logic                       stop_request,
    output logic [TIME_W-1:0]          total_length
);

    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTRY_W = $bits(seg_entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    fsm_state_t state_reg, state_next;

    logic [CNT_W-1:0]  seg_count_reg, seg_count_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [TIME_W-1:0] base_reg, base_next;
    logic [TIME_W-1:0] cur_base_reg, cur_base_next;
    logic [TIME_W-1:0] slt_reg, slt_next;
    logic [TIME_W-1:0] prev_raw_reg, prev_raw_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [TIME_W-1:0] length_sum_reg, length_sum_next;

    logic [ACTION_W-1:0]       act_reg, act_next;
    logic [TIME_W-1:0]         beg_in_reg, beg_in_next;
    logic [TIME_W-1:0]         fin_in_reg, fin_in_next;
    logic [TIME_W-1:0]         t_reg, t_next;
    logic signed [GTIME_W-1:0] gtime_reg, gtime_next;
    logic                      adv_reg, adv_next;
    logic                      wrap_reg, wrap_next;
    logic [TIME_W-1:0]         len_reg, len_next;

    logic                       out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic signed [GTIME_W-1:0]  gtime_out_reg, gtime_out_next;
    logic                       tvalid_reg, tvalid_next;
    logic [INDEX_OUT_W-1:0]     index_reg, index_next;
    logic                       load_reg, load_next;
    logic [TIME_W-1:0]          ltime_reg, ltime_next;
    logic                       stop_reg, stop_next;
    logic [TIME_W-1:0]          total_reg, total_next;

    logic                  out_free;
    logic                  emit;
    logic [STATUS_W-1:0]   res_status;
    logic signed [GTIME_W-1:0] res_gtime;
    logic                  res_tvalid;
    logic                  res_load;
    logic [TIME_W-1:0]     res_ltime;
    logic                  res_stop;

    logic                  ram_we;
    logic                  fsm_re;
    logic [IDX_W-1:0]      fsm_addr;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    seg_entry_t            rd_entry;
    seg_entry_t            wr_entry;

    logic                  walk_start;
    logic                  walk_rd_en;
    logic [IDX_W-1:0]      walk_addr;
    logic [IDX_W-1:0]      walk_hit_idx;
    walk_res_t             walk_res;

    logic [TIME_W-1:0]     fin_fix;
    logic [CNT_W-1:0]      nxt_cnt;
    logic signed [GTIME_W:0] gsum;
    logic [TIME_W-1:0]     adv_base;
    logic [TIME_W-1:0]     seek_slt;

    stm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (seg_count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stm_walk #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .count   (seg_count_reg),
        .target  (t_reg),
        .rd_en   (walk_rd_en),
        .rd_addr (walk_addr),
        .rd_data (rd_entry),
        .res     (walk_res),
        .hit_idx (walk_hit_idx)
    );

    assign rd_entry  = seg_entry_t'(ram_rdata);
    assign ram_re    = walk_rd_en | fsm_re;
    assign ram_raddr = (state_reg == S_WALK) ? walk_addr : fsm_addr;

    assign fin_fix         = (fin_in_reg < beg_in_reg) ? beg_in_reg : fin_in_reg;
    assign wr_entry.beg_ms = beg_in_reg;
    assign wr_entry.fin_ms = fin_fix;

    assign nxt_cnt  = CNT_W'(cur_reg) + 1'b1;
    assign gsum     = $signed({2'b00, base_reg}) + $signed({2'b00, t_reg})
                    - $signed({2'b00, rd_entry.beg_ms});
    assign adv_base = sat_add31(cur_base_reg, len_reg);
    assign seek_slt = walk_res.hit_begin + walk_res.hit_off;

    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        seg_count_next  = seg_count_reg;
        cur_next        = cur_reg;
        base_next       = base_reg;
        cur_base_next   = cur_base_reg;
        slt_next        = slt_reg;
        prev_raw_next   = prev_raw_reg;
        prev_valid_next = prev_valid_reg;
        length_sum_next = length_sum_reg;
        act_next        = act_reg;
        beg_in_next     = beg_in_reg;
        fin_in_next     = fin_in_reg;
        t_next          = t_reg;
        gtime_next      = gtime_reg;
        adv_next        = adv_reg;
        wrap_next       = wrap_reg;
        len_next        = len_reg;

        ram_we     = 1'b0;
        fsm_re     = 1'b0;
        fsm_addr   = cur_reg;
        walk_start = 1'b0;
        emit       = 1'b0;
        res_status = ST_OK;
        res_gtime  = '0;
        res_tvalid = 1'b0;
        res_load   = 1'b0;
        res_ltime  = '0;
        res_stop   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    act_next    = action;
                    beg_in_next = seg_begin;
                    fin_in_next = seg_finish;
                    t_next      = time_value;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (act_reg)
                    ACT_APPEND:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (seg_count_reg == CNT_MAX)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                seg_count_next  = seg_count_reg + 1'b1;
                                length_sum_next = sat_add31(length_sum_reg,
                                                            fin_fix - beg_in_reg);
                            end
                        end
                    end

                    ACT_SEEK:
                    begin
                        if (seg_count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                res_status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            walk_start = 1'b1;
                            state_next = S_WALK;
                        end
                    end

                    ACT_REPORT:
                    begin
                        if (seg_count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                res_status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else if (prev_valid_reg && (t_reg < prev_raw_reg))
                        begin
                            if (out_free)
                            begin
                                emit          = 1'b1;
                                res_status    = ST_BACKWARD;
                                prev_raw_next = t_reg;
                                state_next    = S_IDLE;
                            end
                        end
                        else
                        begin
                            fsm_re     = 1'b1;
                            fsm_addr   = cur_reg;
                            state_next = S_REP_CALC;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_WALK:
            begin
                if (walk_res.done)
                begin
                    state_next = S_SEEK_DONE;
                end
            end

            S_SEEK_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (walk_res.found)
                    begin
                        cur_next      = walk_hit_idx;
                        slt_next      = seek_slt;
                        base_next     = walk_res.hit_before;
                        cur_base_next = walk_res.hit_before;
                        res_ltime     = seek_slt;
                    end
                    else
                    begin
                        base_next = cur_base_reg;
                        res_ltime = slt_reg;
                    end
                end
            end

            S_REP_CALC:
            begin
                if (!gsum[GTIME_W] && gsum[GTIME_W-1])
                begin
                    gtime_next = GTIME_MAX;
                end
                else
                begin
                    gtime_next = gsum[GTIME_W-1:0];
                end
                adv_next        = (t_reg >= rd_entry.fin_ms);
                wrap_next       = (nxt_cnt >= seg_count_reg);
                len_next        = rd_entry.fin_ms - rd_entry.beg_ms;
                prev_raw_next   = t_reg;
                prev_valid_next = 1'b1;
                if ((t_reg >= rd_entry.fin_ms) && (nxt_cnt < seg_count_reg))
                begin
                    fsm_re   = 1'b1;
                    fsm_addr = nxt_cnt[IDX_W-1:0];
                end
                state_next = S_REP_OUT;
            end

            S_REP_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res_gtime  = gtime_reg;
                    res_tvalid = 1'b1;
                    state_next = S_IDLE;
                    if (adv_reg)
                    begin
                        if (wrap_reg)
                        begin
                            cur_next      = '0;
                            cur_base_next = '0;
                            res_stop      = 1'b1;
                        end
                        else
                        begin
                            cur_next      = nxt_cnt[IDX_W-1:0];
                            base_next     = adv_base;
                            cur_base_next = adv_base;
                            res_load      = 1'b1;
                            res_ltime     = rd_entry.beg_ms;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        gtime_out_next = gtime_out_reg;
        tvalid_next    = tvalid_reg;
        index_next     = index_reg;
        load_next      = load_reg;
        ltime_next     = ltime_reg;
        stop_next      = stop_reg;
        total_next     = total_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            gtime_out_next = res_gtime;
            tvalid_next    = res_tvalid;
            index_next     = INDEX_OUT_W'(cur_next);
            load_next      = res_load;
            ltime_next     = res_ltime;
            stop_next      = res_stop;
            total_next     = length_sum_next;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg  <= '0;
            cur_reg        <= '0;
            base_reg       <= '0;
            cur_base_reg   <= '0;
            slt_reg        <= '0;
            prev_raw_reg   <= '0;
            prev_valid_reg <= 1'b0;
            length_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seg_count_reg  <= seg_count_next;
            cur_reg        <= cur_next;
            base_reg       <= base_next;
            cur_base_reg   <= cur_base_next;
            slt_reg        <= slt_next;
            prev_raw_reg   <= prev_raw_next;
            prev_valid_reg <= prev_valid_next;
            length_sum_reg <= length_sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        beg_in_reg    <= beg_in_next;
        fin_in_reg    <= fin_in_next;
        t_reg         <= t_next;
        gtime_reg     <= gtime_next;
        adv_reg       <= adv_next;
        wrap_reg      <= wrap_next;
        len_reg       <= len_next;
        status_reg    <= status_next;
        gtime_out_reg <= gtime_out_next;
        tvalid_reg    <= tvalid_next;
        index_reg     <= index_next;
        load_reg      <= load_next;
        ltime_reg     <= ltime_next;
        stop_reg      <= stop_next;
        total_reg     <= total_next;
    end

    assign result_valid  = out_valid_reg;
    assign status        = status_reg;
    assign global_time   = gtime_out_reg;
    assign time_valid    = tvalid_reg;
    assign segment_index = index_reg;
    assign load_request  = load_reg;
    assign load_time     = ltime_reg;
    assign stop_request  = stop_reg;
    assign total_length  = total_reg;

    `STM_ASSERT_NOW(a_count_bounded, 1'b1, seg_count_reg <= CNT_MAX)
    `STM_ASSERT_NOW(a_cur_in_table, seg_count_reg != '0, CNT_W'(cur_reg) < seg_count_reg)
    `STM_ASSERT_NOW(a_load_stop_excl, result_valid, !(load_request && stop_request))
    `STM_ASSERT_NOW(a_time_only_ok, result_valid && time_valid, status == ST_OK)
    `STM_ASSERT_NEXT(a_accept_to_exec, item_valid && !item_stall, state_reg == S_EXEC)

endmodule
